FILE: hdl/lpmr_pkg.sv
`default_nettype none
// ============================================================================
// lpmr_pkg
// Shared types and constants for the length-prefixed message ring.
// ============================================================================
package lpmr_pkg;

    localparam int unsigned RING_DEPTH_DEF = 4096;
    localparam int unsigned HEADER_BYTES   = 8;
    localparam int unsigned LEN_W          = 12;
    localparam int unsigned SIZE_W         = 13;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_READ  = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    // one accepted item as it travels from the front part to the back part
    typedef struct packed {
        logic              operation;
        logic [7:0]        data_byte;
        logic [LEN_W-1:0]  message_length;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       read_byte;
        logic             last_of_message;
        logic [LEN_W-1:0] front_length;
        logic [LEN_W-1:0] used_bytes;
        logic [LEN_W-1:0] free_bytes;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/lpmr_if.sv
`default_nettype none
// ============================================================================
// lpmr_if
// Valid/ready channel carrying one payload of a given type.
// ============================================================================
interface lpmr_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/lpmr_ram.sv
`default_nettype none
// ============================================================================
// lpmr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module lpmr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: hdl/lpmr_front.sv
`default_nettype none
// ============================================================================
// lpmr_front
// Input stage and two-entry queue feeding the ring engine.
// ============================================================================
module lpmr_front
    import lpmr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lpmr_if.sink      in_ch,
    output      logic q_valid,
    output      item_t q_item,
    input  wire logic q_pop
);
    item_t      buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_item      = buf_reg[rd_reg];

    // pointer and occupancy update
    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_ch.payload;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue overfilled");
`endif
endmodule
`default_nettype wire

FILE: hdl/lpmr_engine.sv
`default_nettype none
// ============================================================================
// lpmr_engine
// Ring engine: writes headers and data, reads front messages, keeps pointers.
// ============================================================================
module lpmr_engine
    import lpmr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_size,
    input  wire logic              q_valid,
    input  wire item_t             q_item,
    output      logic              q_pop,
    lpmr_if.source                 out_ch
);
    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned PW = AW + 1;
    localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
    localparam logic [PW:0]   HDR_P   = (PW+1)'(HEADER_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;  // writing header bytes
    localparam logic [2:0] S_RHDR = 3'd2;  // fetching header bytes
    localparam logic [2:0] S_RDAT = 3'd3;  // fetching one data byte
    localparam logic [2:0] S_OUT  = 3'd4;  // result waiting

    logic [2:0]        state_reg, state_next;
    logic [PW-1:0]     size_reg, size_next;
    logic [PW-1:0]     rp_reg, rp_next, wp_reg, wp_next, pwp_reg, pwp_next;
    logic [LEN_W-1:0]  wleft_reg, wleft_next;
    logic              drop_reg, drop_next;
    logic [LEN_W-1:0]  rdone_reg, rdone_next;
    logic [LEN_W-1:0]  rlen_reg, rlen_next;
    logic [3:0]        step_reg, step_next;
    logic [31:0]       hdr_reg, hdr_next;
    item_t             item_reg, item_next;
    result_t           res_reg, res_next;
    logic              fetch_reg, fetch_next;

    logic              ram_we;
    logic [AW-1:0]     ram_wa, ram_ra;
    logic [7:0]        ram_wd, ram_rd;
    logic [PW-1:0]     used, freeb, ra_p;
    logic [SIZE_W-1:0] eff;

    lpmr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
        .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
        .rd_addr(ram_ra), .rd_data(ram_rd)
    );

    // saturated ring size
    always_comb
    begin
        if (cfg_size < SIZE_W'(16))
        begin
            eff = SIZE_W'(16);
        end
        else if ({{(32-SIZE_W){1'b0}}, cfg_size} > RING_DEPTH)
        begin
            eff = SIZE_W'(RING_DEPTH);
        end
        else
        begin
            eff = cfg_size;
        end
    end

    function automatic logic [PW-1:0] wrap(input logic [PW:0] v,
                                           input logic [PW-1:0] s);
        logic [PW:0] d;
        begin
            d = v - {1'b0, s};
            wrap = (v >= {1'b0, s}) ? d[PW-1:0] : v[PW-1:0];
        end
    endfunction

    assign used  = wrap({1'b0, wp_reg} + {1'b0, size_reg} - {1'b0, rp_reg}, size_reg);
    assign freeb = size_reg - PW'(1) - used;

    assign out_ch.valid   = (state_reg == S_OUT);
    assign out_ch.payload = res_reg;

    // main sequencer
    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        pwp_next   = pwp_reg;
        wleft_next = wleft_reg;
        drop_next  = drop_reg;
        rdone_next = rdone_reg;
        rlen_next  = rlen_reg;
        step_next  = step_reg;
        hdr_next   = hdr_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        fetch_next = 1'b0;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_wd     = 8'd0;
        ram_wa     = pwp_reg[AW-1:0];
        ra_p       = rp_reg;
        ram_ra     = ra_p[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    res_next  = '0;
                    if (q_item.operation == OP_WRITE)
                    begin
                        if (wleft_reg != '0)
                        begin
                            wleft_next = wleft_reg - LEN_W'(1);
                            state_next = S_OUT;
                            if (drop_reg)
                            begin
                                res_next.status = ST_REJECT;
                                if (wleft_reg == LEN_W'(1))
                                begin
                                    drop_next = 1'b0;
                                end
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                ram_wd   = q_item.data_byte;
                                pwp_next = wrap({1'b0, pwp_reg} + 1'b1, size_reg);
                                if (wleft_reg == LEN_W'(1))
                                begin
                                    wp_next = pwp_next;
                                end
                            end
                        end
                        else if (({20'd0, q_item.message_length} + 32'(HEADER_BYTES))
                                 > {{(32-PW){1'b0}}, freeb})
                        begin
                            res_next.status = ST_REJECT;
                            if (q_item.message_length > LEN_W'(1))
                            begin
                                wleft_next = q_item.message_length - LEN_W'(1);
                                drop_next  = 1'b1;
                            end
                            state_next = S_OUT;
                        end
                        else
                        begin
                            pwp_next   = wp_reg;
                            step_next  = '0;
                            state_next = S_HDR;
                        end
                    end
                    else
                    begin
                        if (rdone_reg == '0)
                        begin
                            if (used < PW'(8))
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                step_next  = '0;
                                hdr_next   = '0;
                                state_next = S_RHDR;
                            end
                        end
                        else
                        begin
                            state_next = S_RDAT;
                        end
                    end
                end
            end

            S_HDR:
            begin
                // header bytes, then the first data byte if any
                ram_we = 1'b1;
                if (step_reg < 4'd4)
                begin
                    ram_wd = 8'(({20'd0, item_reg.message_length}) >> {step_reg[1:0], 3'b000});
                end
                else if (step_reg < 4'd8)
                begin
                    ram_wd = 8'd0;
                end
                else
                begin
                    ram_wd = item_reg.data_byte;
                end
                if (step_reg == 4'd8 && item_reg.message_length == '0)
                begin
                    ram_we     = 1'b0;
                    wp_next    = pwp_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    pwp_next  = wrap({1'b0, pwp_reg} + 1'b1, size_reg);
                    step_next = step_reg + 4'd1;
                    if (step_reg == 4'd8)
                    begin
                        wleft_next = item_reg.message_length - LEN_W'(1);
                        if (item_reg.message_length == LEN_W'(1))
                        begin
                            wp_next = pwp_next;
                        end
                        state_next = S_OUT;
                    end
                end
                res_next.used_bytes = '0;
            end

            S_RHDR:
            begin
                // issue addresses 0..7, collect the registered data in the following cycle
                ra_p   = wrap({1'b0, rp_reg} + {{(PW-3){1'b0}}, step_reg[2:0]}, size_reg);
                ram_ra = ra_p[AW-1:0];
                step_next  = step_reg + 4'd1;
                fetch_next = (step_reg < 4'd8);
                if (fetch_reg)
                begin
                    hdr_next = (step_reg <= 4'd4)
                        ? (hdr_reg | ({24'd0, ram_rd} << {step_reg[1:0] - 2'd1, 3'b000}))
                        : hdr_reg;
                    if (step_reg > 4'd4 && ram_rd != 8'd0)
                    begin
                        hdr_next[31] = 1'b1;  // oversized marker
                    end
                end
                if (step_reg == 4'd9)
                begin
                    if (hdr_reg > {{(32-PW){1'b0}}, used - PW'(8)})
                    begin
                        res_next.status = ST_EMPTY;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        rlen_next  = hdr_reg[LEN_W-1:0];
                        if (hdr_reg[LEN_W-1:0] == '0)
                        begin
                            res_next.last_of_message = 1'b1;
                            rp_next    = wrap({1'b0, rp_reg} + HDR_P, size_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            step_next  = '0;
                            state_next = S_RDAT;
                        end
                    end
                end
            end

            S_RDAT:
            begin
                ra_p = wrap({1'b0, wrap({1'b0, rp_reg} + HDR_P, size_reg)}
                            + (PW+1)'(rdone_reg), size_reg);
                ram_ra     = ra_p[AW-1:0];
                fetch_next = 1'b1;
                if (fetch_reg)
                begin
                    fetch_next              = 1'b0;
                    res_next.read_byte      = ram_rd;
                    res_next.front_length   = rlen_reg;
                    rdone_next              = rdone_reg + LEN_W'(1);
                    if (rdone_next >= rlen_reg)
                    begin
                        res_next.last_of_message = 1'b1;
                        rp_next    = wrap({1'b0, rp_reg} + (PW+1)'(rlen_reg)
                                          + HDR_P, size_reg);
                        rdone_next = '0;
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_next == S_OUT && state_reg != S_OUT)
        begin
            res_next.used_bytes = LEN_W'(wrap({1'b0, wp_next} + {1'b0, size_reg}
                                              - {1'b0, rp_next}, size_reg));
            res_next.free_bytes = LEN_W'(size_reg - PW'(1) - wrap({1'b0, wp_next}
                                  + {1'b0, size_reg} - {1'b0, rp_next}, size_reg));
        end

        if (cfg_we)
        begin
            size_next  = PW'(eff);
            rp_next    = '0;
            wp_next    = '0;
            pwp_next   = '0;
            wleft_next = '0;
            drop_next  = 1'b0;
            rdone_next = '0;
            rlen_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= DEPTH_P;
            rp_reg    <= '0;
            wp_reg    <= '0;
            pwp_reg   <= '0;
            wleft_reg <= '0;
            drop_reg  <= 1'b0;
            rdone_reg <= '0;
            rlen_reg  <= '0;
            step_reg  <= '0;
            fetch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            pwp_reg   <= pwp_next;
            wleft_reg <= wleft_next;
            drop_reg  <= drop_next;
            rdone_reg <= rdone_next;
            rlen_reg  <= rlen_next;
            step_reg  <= step_next;
            fetch_reg <= fetch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg  <= hdr_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

`ifndef ASSERT_OFF
    a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg < size_reg) else $error("read pointer past ring size");
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < size_reg) else $error("write pointer past ring size");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE) else $error("pop while busy");
    a_drop_left: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> wleft_reg != '0) else $error("dropping with no bytes left");
`endif
endmodule
`default_nettype wire

FILE: hdl/length_prefixed_message_ring_unit.sv
`default_nettype none
// ============================================================================
// length_prefixed_message_ring_unit
// Byte ring queue of whole messages with 8-byte length headers.
// ============================================================================
// A data byte of a message in progress is written directly from idle; the first
// write item of a message also passes through the header state, since the engine
// stores the eight header bytes through the single RAM write port. A read of a
// message's first byte first makes eight header fetches through the registered
// RAM read port; later bytes skip the header. A two-entry queue in front lets
// the input side keep accepting while a result waits.
module length_prefixed_message_ring_unit
    import lpmr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lpmr_if.sink      in_ch,
    lpmr_if.source    out_ch,
    lpmr_if.sink      cfg_ch
);
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ch.ready = 1'b1;

    lpmr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    lpmr_engine #(.RING_DEPTH(RING_DEPTH)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_ch.valid), .cfg_size(cfg_ch.payload),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_ch(out_ch)
    );
endmodule
`default_nettype wire
